### sv/vrs_pkg.sv
// ----------------------------------------------------------------------------
// vrs_pkg: shared types and constants of the rope step block
// Fixed point widths, payload structs, register codes, sequencer states and
// the 24-bit position saturation used by the datapath.
// ----------------------------------------------------------------------------
package vrs_pkg;

  // Position and datapath widths
  localparam int PW   = 24;  // Q15.8 position
  localparam int SATW = 30;  // headroom for sums before saturation
  localparam int DW   = 25;  // difference of two positions
  localparam int DVW  = 26;  // divisor / length minus distance
  localparam int MW   = 51;  // shared multiplier product
  localparam int SQW  = 50;  // squared distance
  localparam int RW   = 25;  // square root
  localparam int NW   = 52;  // rounded dividend magnitude
  localparam int CW   = 28;  // clamped correction

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 24;

  typedef logic signed [PW-1:0] pos_t;

  // Configuration register codes
  localparam logic [CFG_IW-1:0] CFG_ANCHOR_OFF_X = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_ANCHOR_OFF_Y = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_END_OFF_X    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_END_OFF_Y    = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_END_ATTACHED = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_SEG_LEN      = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_GRAVITY      = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_FRICTION     = 3'd7;

  // Operation codes
  localparam logic OP_INIT   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic operation;
    pos_t anchor_x;
    pos_t anchor_y;
  } vrs_in_t;

  typedef struct packed {
    logic [5:0] point_index;
    pos_t       point_x;
    pos_t       point_y;
    pos_t       end_x;
    pos_t       end_y;
    logic       end_valid;
    logic       last;
  } vrs_out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT, ST_PIN, ST_GRD, ST_GWR,
    ST_LRD0, ST_LRD1, ST_LRD2, ST_MXX, ST_MYY, ST_SQST, ST_SQWT,
    ST_MCX, ST_DVX, ST_DXWT, ST_MCY, ST_DVY, ST_DYWT, ST_WRI, ST_WRP,
    ST_FRD, ST_FCAP, ST_FMX, ST_FMY, ST_FWR, ST_ORD, ST_OLD
  } vrs_state_e;

  localparam logic signed [SATW-1:0] SAT_HI = SATW'(2**(PW-1) - 1);
  localparam logic signed [SATW-1:0] SAT_LO = -SAT_HI - SATW'(1);

  // Clamp a wide signed value to the 24-bit position range
  function automatic pos_t sat_pos(input logic signed [SATW-1:0] v);
    pos_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[PW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[PW-1:0];
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

endpackage

### sv/vrs_store.sv
// ----------------------------------------------------------------------------
// vrs_store: one position store
// Single write port, one registered read port; per-entry valid bits make
// entries read as zero until written after reset.
// ----------------------------------------------------------------------------
module vrs_store import vrs_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  pos_t          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output pos_t          rdata_o
);

  pos_t             mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  pos_t             rdata_q;

  // Track written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= vld_q[raddr_i] ? mem[raddr_i] : '0;
  end

  assign rdata_o = rdata_q;

endmodule

### sv/vrs_isqrt.sv
// ----------------------------------------------------------------------------
// vrs_isqrt: iterative integer square root
// Digit-by-digit method, one result bit per cycle, floor of the root.
// ----------------------------------------------------------------------------
module vrs_isqrt import vrs_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [SQW-1:0] rad_i,
  output logic           done_o,
  output logic [RW-1:0]  root_o
);

  logic [SQW-1:0] v_q, r_q, b_q;
  logic           busy_q, done_q;
  logic [SQW-1:0] trial;

  assign trial = r_q + b_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && b_q == SQW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Advance one bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= rad_i;
      r_q <= '0;
      b_q <= SQW'(1) << (SQW - 2);
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + b_q;
      end else begin
        r_q <= r_q >> 1;
      end
      b_q <= b_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[RW-1:0];

endmodule

### sv/vrs_rdiv.sv
// ----------------------------------------------------------------------------
// vrs_rdiv: iterative rounding divider
// Signed dividend over positive divisor, rounded half away from zero,
// restoring shift-subtract one bit per cycle; result clamped to +/-2^26.
// ----------------------------------------------------------------------------
module vrs_rdiv import vrs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [MW-1:0]  num_i,
  input  logic [DVW-1:0]        den_i,
  output logic                  done_o,
  output logic signed [CW-1:0]  quo_o
);

  localparam int CNTW = $clog2(NW + 1);
  localparam logic [NW-1:0] LIM = NW'(1) << (CW - 2);

  logic [NW-1:0]   dvd_q;
  logic [DVW-1:0]  rem_q, den_q;
  logic [CNTW-1:0] cnt_q;
  logic            neg_q, busy_q, done_q;
  logic [MW-1:0]   mag;
  logic [DVW:0]    rem_sh;
  logic            ge;
  logic [NW-1:0]   qclamp;

  assign mag    = num_i[MW-1] ? MW'(-num_i) : MW'(num_i);
  assign rem_sh = {rem_q, dvd_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign qclamp = (dvd_q > LIM) ? LIM : dvd_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift and subtract
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= NW'(mag) + NW'(den_i >> 1);
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[MW-1];
    end else if (busy_q) begin
      rem_q <= ge ? DVW'(rem_sh - {1'b0, den_q}) : rem_sh[DVW-1:0];
      dvd_q <= {dvd_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(qclamp[CW-1:0]) : $signed(qclamp[CW-1:0]);

endmodule

### sv/verlet_rope_step.sv
// ----------------------------------------------------------------------------
// verlet_rope_step: rope of point masses, Verlet step with link relaxation
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (vrs_in_t)
//   out     | output    | out_valid_o / out_ready_i| out_data_o (vrs_out_t)
//   cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// An update item's run time is set by the bit-serial square root and the
// two divides per link; a link of zero length skips the divides.
// One item at a time; in_ready_o is high only while the sequencer is idle.
// Results leave through an output register; a stalled output holds the
// sequencer. Reset clears control and makes every store read as zero.
// ----------------------------------------------------------------------------
module verlet_rope_step import vrs_pkg::*; #(
  parameter int SEGMENTS   = 16,
  parameter int ITERATIONS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vrs_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vrs_out_t          out_data_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i
);

  localparam int IW = $clog2(SEGMENTS);
  localparam int JW = $clog2(ITERATIONS) + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SEGMENTS - 1);
  localparam logic [JW-1:0] LAST_IT  = JW'(ITERATIONS - 1);

  // Configuration registers
  pos_t        anc_off_x_q, anc_off_y_q, end_off_x_q, end_off_y_q;
  logic        end_att_q;
  logic [15:0] seg_len_q;
  logic [15:0] grav_q;
  logic [8:0]  fric_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anc_off_x_q <= '0;
      anc_off_y_q <= '0;
      end_off_x_q <= '0;
      end_off_y_q <= '0;
      end_att_q   <= 1'b0;
      seg_len_q   <= 16'd2048;
      grav_q      <= 16'd256;
      fric_q      <= 9'd243;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ANCHOR_OFF_X: anc_off_x_q <= cfg_wdata_i;
        CFG_ANCHOR_OFF_Y: anc_off_y_q <= cfg_wdata_i;
        CFG_END_OFF_X:    end_off_x_q <= cfg_wdata_i;
        CFG_END_OFF_Y:    end_off_y_q <= cfg_wdata_i;
        CFG_END_ATTACHED: end_att_q   <= cfg_wdata_i[0];
        CFG_SEG_LEN:      seg_len_q   <= cfg_wdata_i[15:0];
        CFG_GRAVITY:      grav_q      <= cfg_wdata_i[15:0];
        CFG_FRICTION:     fric_q      <= cfg_wdata_i[8:0];
      endcase
    end
  end

  // Sequencer and datapath registers
  vrs_state_e              state_q, state_d;
  logic [IW-1:0]           i_q, i_d;
  logic [JW-1:0]           j_q, j_d;
  pos_t                    ax_q, ay_q, x0_q, y0_q, x1_q, y1_q, qx_q, qy_q;
  logic signed [SATW-1:0]  y_q;
  logic signed [DW-1:0]    dx_q, dy_q;
  logic [SQW-1:0]          sum_q;
  logic signed [MW-1:0]    prod_q;
  logic [RW-1:0]           d_q;
  logic signed [CW-1:0]    cx_q, cy_q, fx_q;
  vrs_out_t                out_q;
  logic                    out_valid_q;

  // Store ports
  logic [IW-1:0] rd_addr, wa;
  logic          we_px, we_py, we_qx, we_qy;
  pos_t          wd_px, wd_py, wd_qx, wd_qy;
  pos_t          rd_px, rd_py, rd_qx, rd_qy;

  // Shared multiplier and units
  logic                   mul_en;
  logic signed [DW-1:0]   mul_a;
  logic signed [DVW-1:0]  mul_b;
  logic                   sq_start, sq_done, dv_start, dv_done;
  logic [RW-1:0]          sq_root;
  logic signed [CW-1:0]   dv_quo;
  logic [DVW-1:0]         dv_den;
  logic signed [DVW-1:0]  len_m_d;
  logic                   link_adv, out_load;
  pos_t                   ax_in, ay_in;
  logic signed [CW-1:0]   fy_rnd;

  function automatic logic signed [CW-1:0] rnd256(input logic signed [MW-1:0] p);
    logic [MW-1:0] mag;
    logic [MW-1:0] q;
    mag = p[MW-1] ? MW'(-p) : MW'(p);
    q   = (mag + MW'(128)) >> 8;
    return p[MW-1] ? -$signed(q[CW-1:0]) : $signed(q[CW-1:0]);
  endfunction

  assign ax_in   = sat_pos(SATW'(in_data_i.anchor_x) + SATW'(anc_off_x_q));
  assign ay_in   = sat_pos(SATW'(in_data_i.anchor_y) + SATW'(anc_off_y_q));
  assign len_m_d = $signed({{(DVW-16){1'b0}}, seg_len_q}) - $signed({1'b0, d_q});
  assign dv_den  = (i_q == IW'(1)) ? {1'b0, d_q} : {d_q, 1'b0};
  assign fy_rnd  = rnd256(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  // Next state and store / unit controls
  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    rd_addr  = i_q;
    wa       = i_q;
    we_px    = 1'b0;
    we_py    = 1'b0;
    we_qx    = 1'b0;
    we_qy    = 1'b0;
    wd_px    = x1_q;
    wd_py    = y1_q;
    wd_qx    = x1_q;
    wd_qy    = y1_q;
    mul_en   = 1'b0;
    mul_a    = dx_q;
    mul_b    = DVW'(dx_q);
    sq_start = 1'b0;
    dv_start = 1'b0;
    link_adv = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          i_d     = '0;
          j_d     = '0;
          state_d = (in_data_i.operation == OP_UPDATE) ? ST_PIN : ST_INIT;
        end
      end
      ST_INIT: begin
        {we_px, we_py, we_qx, we_qy} = 4'b1111;
        wd_px = ax_q;
        wd_py = sat_pos(y_q);
        wd_qx = ax_q;
        wd_qy = sat_pos(y_q);
        if (i_q == LAST_IDX) begin
          i_d     = '0;
          state_d = ST_ORD;
        end else begin
          i_d = i_q + IW'(1);
        end
      end
      ST_PIN: begin
        we_px   = 1'b1;
        we_py   = 1'b1;
        wa      = '0;
        wd_px   = ax_q;
        wd_py   = ay_q;
        i_d     = IW'(1);
        state_d = ST_GRD;
      end
      ST_GRD: state_d = ST_GWR;
      ST_GWR: begin
        we_py = 1'b1;
        wd_py = sat_pos(SATW'(rd_py) + SATW'($signed(grav_q)));
        if (i_q == LAST_IDX) begin
          i_d     = IW'(1);
          j_d     = '0;
          state_d = ST_LRD0;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = ST_GRD;
        end
      end
      ST_LRD0: begin
        rd_addr = i_q - IW'(1);
        state_d = ST_LRD1;
      end
      ST_LRD1: state_d = ST_LRD2;
      ST_LRD2: state_d = ST_MXX;
      ST_MXX: begin
        mul_en  = 1'b1;
        state_d = ST_MYY;
      end
      ST_MYY: begin
        mul_en  = 1'b1;
        mul_a   = dy_q;
        mul_b   = DVW'(dy_q);
        state_d = ST_SQST;
      end
      ST_SQST: begin
        sq_start = 1'b1;
        state_d  = ST_SQWT;
      end
      ST_SQWT: begin
        if (sq_done) begin
          if (sq_root == '0) begin
            link_adv = 1'b1;
          end else begin
            state_d = ST_MCX;
          end
        end
      end
      ST_MCX: begin
        mul_en  = 1'b1;
        mul_b   = len_m_d;
        state_d = ST_DVX;
      end
      ST_DVX: begin
        dv_start = 1'b1;
        state_d  = ST_DXWT;
      end
      ST_DXWT: if (dv_done) state_d = ST_MCY;
      ST_MCY: begin
        mul_en  = 1'b1;
        mul_a   = dy_q;
        mul_b   = len_m_d;
        state_d = ST_DVY;
      end
      ST_DVY: begin
        dv_start = 1'b1;
        state_d  = ST_DYWT;
      end
      ST_DYWT: if (dv_done) state_d = ST_WRI;
      ST_WRI: begin
        we_px = 1'b1;
        we_py = 1'b1;
        wd_px = sat_pos(SATW'(x1_q) + SATW'(cx_q));
        wd_py = sat_pos(SATW'(y1_q) + SATW'(cy_q));
        if (i_q == IW'(1)) begin
          link_adv = 1'b1;
        end else begin
          state_d = ST_WRP;
        end
      end
      ST_WRP: begin
        we_px    = 1'b1;
        we_py    = 1'b1;
        wa       = i_q - IW'(1);
        wd_px    = sat_pos(SATW'(x0_q) - SATW'(cx_q));
        wd_py    = sat_pos(SATW'(y0_q) - SATW'(cy_q));
        link_adv = 1'b1;
      end
      ST_FRD:  state_d = ST_FCAP;
      ST_FCAP: state_d = ST_FMX;
      ST_FMX: begin
        mul_en  = 1'b1;
        mul_a   = $signed({{(DW-9){1'b0}}, fric_q});
        mul_b   = DVW'(DW'(x1_q) - DW'(qx_q));
        state_d = ST_FMY;
      end
      ST_FMY: begin
        mul_en  = 1'b1;
        mul_a   = $signed({{(DW-9){1'b0}}, fric_q});
        mul_b   = DVW'(DW'(y1_q) - DW'(qy_q));
        state_d = ST_FWR;
      end
      ST_FWR: begin
        {we_px, we_py, we_qx, we_qy} = 4'b1111;
        wd_px = sat_pos(SATW'(x1_q) + SATW'(fx_q));
        wd_py = sat_pos(SATW'(y1_q) + SATW'(fy_rnd));
        wd_qx = x1_q;
        wd_qy = y1_q;
        if (i_q == LAST_IDX) begin
          i_d     = '0;
          state_d = ST_ORD;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = ST_FRD;
        end
      end
      ST_ORD: state_d = ST_OLD;
      ST_OLD: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          if (i_q == LAST_IDX) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + IW'(1);
            state_d = ST_ORD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Advance to the next link, pass or the friction sweep
    if (link_adv) begin
      if (i_q == LAST_IDX) begin
        i_d = IW'(1);
        if (j_q == LAST_IT) begin
          state_d = ST_FRD;
        end else begin
          j_d     = j_q + JW'(1);
          state_d = ST_LRD0;
        end
      end else begin
        i_d     = i_q + IW'(1);
        state_d = ST_LRD0;
      end
    end
  end

  // Datapath captures
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      ax_q <= ax_in;
      ay_q <= ay_in;
      y_q  <= SATW'(ay_in);
    end
    if (state_q == ST_INIT) begin
      y_q <= y_q + $signed({{(SATW-16){1'b0}}, seg_len_q});
    end
    if (state_q == ST_LRD1) begin
      x0_q <= rd_px;
      y0_q <= rd_py;
    end
    if (state_q == ST_LRD2) begin
      x1_q <= rd_px;
      y1_q <= rd_py;
      dx_q <= DW'(rd_px) - DW'(x0_q);
      dy_q <= DW'(rd_py) - DW'(y0_q);
    end
    if (state_q == ST_FCAP) begin
      x1_q <= rd_px;
      y1_q <= rd_py;
      qx_q <= rd_qx;
      qy_q <= rd_qy;
    end
    if (mul_en) begin
      prod_q <= MW'(mul_a * mul_b);
    end
    if (state_q == ST_MYY) begin
      sum_q <= prod_q[SQW-1:0];
    end
    if (state_q == ST_SQWT && sq_done) begin
      d_q <= sq_root;
    end
    if (state_q == ST_DXWT && dv_done) begin
      cx_q <= dv_quo;
    end
    if (state_q == ST_DYWT && dv_done) begin
      cy_q <= dv_quo;
    end
    if (state_q == ST_FMY) begin
      fx_q <= fy_rnd;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.point_index <= 6'(i_q);
      out_q.point_x     <= rd_px;
      out_q.point_y     <= rd_py;
      out_q.last        <= (i_q == LAST_IDX);
      if (i_q == LAST_IDX && end_att_q) begin
        out_q.end_x     <= sat_pos(SATW'(rd_px) + SATW'(end_off_x_q));
        out_q.end_y     <= sat_pos(SATW'(rd_py) + SATW'(end_off_y_q));
        out_q.end_valid <= 1'b1;
      end else begin
        out_q.end_x     <= '0;
        out_q.end_y     <= '0;
        out_q.end_valid <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Position and previous position stores
  vrs_store #(.DEPTH(SEGMENTS), .AW(IW)) u_pos_x (
    .clk_i, .rst_ni, .we_i(we_px), .waddr_i(wa), .wdata_i(wd_px),
    .raddr_i(rd_addr), .rdata_o(rd_px)
  );
  vrs_store #(.DEPTH(SEGMENTS), .AW(IW)) u_pos_y (
    .clk_i, .rst_ni, .we_i(we_py), .waddr_i(wa), .wdata_i(wd_py),
    .raddr_i(rd_addr), .rdata_o(rd_py)
  );
  vrs_store #(.DEPTH(SEGMENTS), .AW(IW)) u_prev_x (
    .clk_i, .rst_ni, .we_i(we_qx), .waddr_i(wa), .wdata_i(wd_qx),
    .raddr_i(rd_addr), .rdata_o(rd_qx)
  );
  vrs_store #(.DEPTH(SEGMENTS), .AW(IW)) u_prev_y (
    .clk_i, .rst_ni, .we_i(we_qy), .waddr_i(wa), .wdata_i(wd_qy),
    .raddr_i(rd_addr), .rdata_o(rd_qy)
  );

  // Link length and correction units
  vrs_isqrt u_isqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(sum_q + prod_q[SQW-1:0]),
    .done_o(sq_done), .root_o(sq_root)
  );

  vrs_rdiv u_rdiv (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(prod_q), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo)
  );

endmodule

### sv/vrs_checker.sv
// ----------------------------------------------------------------------------
// vrs_checker: port-level checks for the rope step block
// Watches the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module vrs_checker import vrs_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input vrs_out_t          out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // End position only on the final point
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_valid |-> out_data_o.last)
    else $error("end position before final point");

  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |->
      out_data_o.end_x == '0 && out_data_o.end_y == '0)
    else $error("end position not zero on inner point");

  // Stay busy while a run still has points to report
  a_busy_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("input taken mid run");

  a_busy_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after transfer");

endmodule

bind verlet_rope_step vrs_checker u_vrs_checker (.*);
